/* rtl/pfe_pkg.sv */
package pfe_pkg;

  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned PtrW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DataW       = 32;
  localparam int unsigned TokW        = 8;
  localparam int unsigned NumVars     = 4;
  localparam int unsigned VarIdxW     = $clog2(NumVars);
  localparam int unsigned AddrW       = VarIdxW + 2;
  localparam int unsigned StepW       = $clog2(DataW);

  localparam logic [TokW-1:0] TOK_A     = 8'h41;
  localparam logic [TokW-1:0] TOK_D     = 8'h44;
  localparam logic [TokW-1:0] TOK_PLUS  = 8'h2B;
  localparam logic [TokW-1:0] TOK_MINUS = 8'h2D;
  localparam logic [TokW-1:0] TOK_MUL   = 8'h2A;
  localparam logic [TokW-1:0] TOK_DIV   = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

/* rtl/pfe_alu.sv */
module pfe_alu
  import pfe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alu_req_t         req_i,
  input  logic [DataW-1:0] opa_i,
  input  logic [DataW-1:0] opb_i,
  output alu_stat_t        stat_o,
  output logic [DataW-1:0] result_o
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIN
  } alu_state_e;

  alu_state_e       state_q, state_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic             is_div_q, is_div_d;
  logic             neg_q, neg_d;
  logic [DataW-1:0] opa_q, opa_d;
  logic [DataW-1:0] opb_q, opb_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] res_q, res_d;
  logic [DataW:0]   shifted;
  logic [DataW:0]   trial;

  assign shifted = {acc_q, opa_q[DataW-1]};
  assign trial   = shifted - {1'b0, opb_q};

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    step_d   = step_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    acc_d    = acc_q;
    res_d    = res_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          is_div_d = req_i.is_div;
          step_d   = '0;
          acc_d    = '0;
          state_d  = A_RUN;
          if (req_i.is_div) begin
            neg_d = opa_i[DataW-1] ^ opb_i[DataW-1];
            opa_d = opa_i[DataW-1] ? (~opa_i + 1'b1) : opa_i;
            opb_d = opb_i[DataW-1] ? (~opb_i + 1'b1) : opb_i;
          end else begin
            neg_d = 1'b0;
            opa_d = opa_i;
            opb_d = opb_i;
          end
        end
      end
      A_RUN: begin
        if (is_div_q) begin
          if (!trial[DataW]) begin
            acc_d = trial[DataW-1:0];
            opa_d = {opa_q[DataW-2:0], 1'b1};
          end else begin
            acc_d = shifted[DataW-1:0];
            opa_d = {opa_q[DataW-2:0], 1'b0};
          end
        end else begin
          if (opb_q[0]) begin
            acc_d = acc_q + opa_q;
          end
          opa_d = {opa_q[DataW-2:0], 1'b0};
          opb_d = {1'b0, opb_q[DataW-1:1]};
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DataW - 1)) begin
          state_d = A_FIN;
        end
      end
      A_FIN: begin
        if (is_div_q) begin
          res_d = neg_q ? (~opa_q + 1'b1) : opa_q;
        end else begin
          res_d = acc_q;
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
  end

  assign stat_o.busy = (state_q != A_IDLE);
  assign stat_o.done = done_q;
  assign result_o    = res_q;

endmodule

/* rtl/postfix_expression_evaluator.sv */
// An operand token A to D is pushed without popping; +, - and other discarding
// bytes pop two operands, and * and / are bounded by the 32-step shared multiply
// and divide unit; a zero divisor skips the unit.
// A final token pops the result before the result transfer is offered, also
// on an empty stack, after any wait for the previous result to be taken.
// Tokens are taken one at a time.
// Reset: rst_ni is asynchronous and active low; it empties the stack and
// clears the status and the variable registers.
module postfix_expression_evaluator
  import pfe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] token_char
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] result_value
  output logic [1:0]       m_axis_tuser,   // [1:0] status_code
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_R,
    S_GET_R,
    S_POP_L,
    S_GET_L,
    S_OP,
    S_WAIT,
    S_PUSH,
    S_FIN_POP,
    S_FIN_GET,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  status_e          sticky_q, sticky_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  status_e          out_stat_q, out_stat_d;
  logic [TokW-1:0]  tok_q, tok_d;
  logic             last_q, last_d;
  logic [DataW-1:0] right_q, right_d;
  logic [DataW-1:0] left_q, left_d;
  logic [DataW-1:0] res_q, res_d;
  logic [DataW-1:0] var_q [NumVars];

  logic [DataW-1:0] stack_mem [STACK_DEPTH];
  logic [DataW-1:0] rd_q;
  logic             mem_we;
  logic [CntW-1:0]  cnt_m1;
  logic [TokW-1:0]  tok_off;
  logic             in_xfer;
  logic             cfg_we;

  alu_req_t         alu_req;
  alu_stat_t        alu_stat;
  logic [DataW-1:0] alu_res;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign prdata  = var_q[paddr[AddrW-1:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumVars; i++) begin
        var_q[i] <= '0;
      end
    end else if (cfg_we) begin
      var_q[paddr[AddrW-1:2]] <= pwdata;
    end
  end

  assign cnt_m1        = cnt_q - 1'b1;
  assign tok_off       = s_axis_tdata - TOK_A;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[cnt_q[PtrW-1:0]] <= res_q;
    end
    rd_q <= stack_mem[cnt_m1[PtrW-1:0]];
  end

  pfe_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .opa_i    (left_q),
    .opb_i    (right_q),
    .stat_o   (alu_stat),
    .result_o (alu_res)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sticky_d    = sticky_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_stat_d  = out_stat_q;
    tok_d       = tok_q;
    last_d      = last_q;
    right_d     = right_q;
    left_d      = left_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    alu_req     = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          tok_d  = s_axis_tdata;
          last_d = s_axis_tlast;
          if (s_axis_tdata >= TOK_A && s_axis_tdata <= TOK_D) begin
            res_d   = var_q[tok_off[VarIdxW-1:0]];
            state_d = S_PUSH;
          end else begin
            state_d = S_POP_R;
          end
        end
      end
      S_POP_R: begin
        if (cnt_q == '0) begin
          if (sticky_q == ST_OK) sticky_d = ST_UNDERFLOW;
          right_d = '0;
          state_d = S_POP_L;
        end else begin
          cnt_d   = cnt_m1;
          state_d = S_GET_R;
        end
      end
      S_GET_R: begin
        right_d = rd_q;
        state_d = S_POP_L;
      end
      S_POP_L: begin
        if (cnt_q == '0) begin
          if (sticky_q == ST_OK) sticky_d = ST_UNDERFLOW;
          left_d  = '0;
          state_d = S_OP;
        end else begin
          cnt_d   = cnt_m1;
          state_d = S_GET_L;
        end
      end
      S_GET_L: begin
        left_d  = rd_q;
        state_d = S_OP;
      end
      S_OP: begin
        case (tok_q)
          TOK_PLUS: begin
            res_d   = left_q + right_q;
            state_d = S_PUSH;
          end
          TOK_MINUS: begin
            res_d   = left_q - right_q;
            state_d = S_PUSH;
          end
          TOK_MUL: begin
            alu_req.start  = 1'b1;
            alu_req.is_div = 1'b0;
            state_d        = S_WAIT;
          end
          TOK_DIV: begin
            if (right_q == '0) begin
              if (sticky_q == ST_OK) sticky_d = ST_DIVZERO;
              res_d   = '0;
              state_d = S_PUSH;
            end else begin
              alu_req.start  = 1'b1;
              alu_req.is_div = 1'b1;
              state_d        = S_WAIT;
            end
          end
          default: state_d = last_q ? S_FIN_POP : S_IDLE;
        endcase
      end
      S_WAIT: begin
        if (alu_stat.done) begin
          res_d   = alu_res;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (cnt_q == CntW'(STACK_DEPTH)) begin
          if (sticky_q == ST_OK) sticky_d = ST_OVERFLOW;
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        state_d = last_q ? S_FIN_POP : S_IDLE;
      end
      S_FIN_POP: begin
        if (cnt_q == '0) begin
          if (sticky_q == ST_OK) sticky_d = ST_UNDERFLOW;
          res_d   = '0;
          state_d = S_EMIT;
        end else begin
          cnt_d   = cnt_m1;
          state_d = S_FIN_GET;
        end
      end
      S_FIN_GET: begin
        res_d   = rd_q;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          out_stat_d  = sticky_q;
          cnt_d       = '0;
          sticky_d    = ST_OK;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sticky_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_stat_q <= out_stat_d;
    tok_q      <= tok_d;
    last_q     <= last_d;
    right_q    <= right_d;
    left_q     <= left_d;
    res_q      <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  a_ready_alu_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !alu_stat.busy)
    else $error("input ready while the arithmetic unit is busy");

  a_emit_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result presented outside the emit step");
`endif

endmodule
